// ----- hw/rtl/bffe_pkg.sv -----
package bffe_pkg;

    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = 64;

    localparam int ADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int CAPACITY = WORD_BITS * NUM_WORDS;
    localparam int CAP_W    = $clog2(CAPACITY + 1);

    localparam int CMD_W = 3;
    localparam int IDX_W = 12;
    localparam int CFG_W = 13;
    localparam int CNT_W = (CAP_W > CFG_W) ? CAP_W : CFG_W;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index as seen at paddr[2]
    localparam logic REG_BIT_COUNT = 1'b0;

    localparam logic [CFG_W-1:0] BIT_COUNT_RST = CFG_W'(4096);

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET       = 3'd0,
        CMD_CLEAR     = 3'd1,
        CMD_TEST      = 3'd2,
        CMD_FIND_SET  = 3'd3,
        CMD_FIND_CLR  = 3'd4,
        CMD_SET_ALL   = 3'd5,
        CMD_CLEAR_ALL = 3'd6
    } cmd_t;

    typedef struct packed {
        logic             bit_value;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic             index_error;
        logic             all_clear;
        logic             all_set;
    } res_t;

    // position of the lowest set bit; 0 when none
    function automatic logic [BIT_W-1:0] lowest_set(input word_t w);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                p = BIT_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// ----- hw/rtl/bffe_core.sv -----
module bffe_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bffe_pkg::CMD_W-1:0]  command,
    input  logic [bffe_pkg::IDX_W-1:0]  bit_index,
    input  logic [bffe_pkg::CFG_W-1:0]  bit_count,
    output logic                        res_valid,
    input  logic                        res_take,
    output bffe_pkg::res_t              res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    localparam logic [bffe_pkg::ADDR_W-1:0] LAST_WORD =
        bffe_pkg::ADDR_W'(bffe_pkg::NUM_WORDS - 1);
    localparam logic [bffe_pkg::CNT_W-1:0] STEP = bffe_pkg::CNT_W'(bffe_pkg::WORD_BITS);
    localparam logic [bffe_pkg::CNT_W-1:0] CAP  = bffe_pkg::CNT_W'(bffe_pkg::CAPACITY);

    state_t                         state_reg;
    bffe_pkg::cmd_t                 cmd_reg;
    logic [bffe_pkg::CNT_W-1:0]     idx_reg;
    logic [bffe_pkg::CNT_W-1:0]     cnt_reg;
    logic                           err_reg;
    logic [bffe_pkg::ADDR_W-1:0]    rd_ptr_reg;
    logic                           iss_done_reg;
    logic                           proc_vld_reg;
    logic                           proc_last_reg;
    logic [bffe_pkg::ADDR_W-1:0]    proc_ptr_reg;
    logic [bffe_pkg::CNT_W-1:0]     lo_reg;
    logic                           rd_ok_reg;
    bffe_pkg::word_t                rd_raw_reg;
    logic [bffe_pkg::NUM_WORDS-1:0] vld_reg;
    bffe_pkg::word_t                mem [bffe_pkg::NUM_WORDS];

    logic                           bv_reg;
    logic                           found_reg;
    logic [bffe_pkg::IDX_W-1:0]     fidx_reg;
    logic                           ac_reg;
    logic                           as_reg;

    logic                           acc;
    logic [bffe_pkg::CNT_W-1:0]     cnt_in;
    logic [bffe_pkg::CNT_W-1:0]     idx_in;
    logic                           err_in;

    bffe_pkg::word_t                old_word;
    bffe_pkg::word_t                new_word;
    bffe_pkg::word_t                used_m;
    bffe_pkg::word_t                want_v;
    logic [bffe_pkg::CNT_W-1:0]     rem;
    logic [bffe_pkg::CNT_W-1:0]     rel;
    logic [bffe_pkg::BIT_W-1:0]     pos;
    logic                           hit;
    logic                           is_find;
    logic                           bv_w;
    logic                           find_hit;
    logic [bffe_pkg::CNT_W-1:0]     fidx_w;

    assign in_ready = (state_reg == S_IDLE);
    assign acc      = in_valid && in_ready;
    assign cnt_in   = (bffe_pkg::CNT_W'(bit_count) > CAP) ? CAP : bffe_pkg::CNT_W'(bit_count);
    assign idx_in   = bffe_pkg::CNT_W'(bit_index);
    assign err_in   = (command == bffe_pkg::CMD_SET || command == bffe_pkg::CMD_CLEAR ||
                       command == bffe_pkg::CMD_TEST) && (idx_in >= cnt_in);

    assign old_word = rd_ok_reg ? rd_raw_reg : '0;

    // per-word modify for the word now coming out of the memory
    always_comb
    begin
        rem    = cnt_reg - lo_reg;
        if (cnt_reg <= lo_reg)
        begin
            used_m = '0;
        end
        else if (rem >= STEP)
        begin
            used_m = '1;
        end
        else
        begin
            used_m = ~({bffe_pkg::WORD_BITS{1'b1}} << rem[bffe_pkg::BIT_W-1:0]);
        end

        rel = idx_reg - lo_reg;
        pos = rel[bffe_pkg::BIT_W-1:0];
        hit = !err_reg && (idx_reg >= lo_reg) && (idx_reg < lo_reg + STEP);

        new_word = old_word;
        bv_w     = 1'b0;
        is_find  = 1'b0;
        want_v   = '0;
        case (cmd_reg)
            bffe_pkg::CMD_SET:
            begin
                if (hit)
                begin
                    new_word[pos] = 1'b1;
                end
            end
            bffe_pkg::CMD_CLEAR:
            begin
                if (hit)
                begin
                    new_word[pos] = 1'b0;
                end
            end
            bffe_pkg::CMD_TEST:
            begin
                bv_w = hit && old_word[pos];
            end
            bffe_pkg::CMD_FIND_SET:
            begin
                is_find = 1'b1;
                want_v  = old_word & used_m;
            end
            bffe_pkg::CMD_FIND_CLR:
            begin
                is_find = 1'b1;
                want_v  = ~old_word & used_m;
            end
            bffe_pkg::CMD_SET_ALL:
            begin
                new_word = '1;
            end
            bffe_pkg::CMD_CLEAR_ALL:
            begin
                new_word = '0;
            end
            default:
            begin
                new_word = old_word;
            end
        endcase

        find_hit = is_find && (want_v != '0);
        fidx_w   = lo_reg + bffe_pkg::CNT_W'(bffe_pkg::lowest_set(want_v));
    end

    // word store: one read and one write-back per cycle
    always_ff @(posedge clk)
    begin
        if (proc_vld_reg)
        begin
            mem[proc_ptr_reg] <= new_word;
        end
        rd_raw_reg <= mem[rd_ptr_reg];
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= vld_reg[rd_ptr_reg];
            if (proc_vld_reg)
            begin
                vld_reg[proc_ptr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= bffe_pkg::CMD_TEST;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            rd_ptr_reg    <= '0;
            iss_done_reg  <= 1'b0;
            proc_vld_reg  <= 1'b0;
            proc_last_reg <= 1'b0;
            proc_ptr_reg  <= '0;
            lo_reg        <= '0;
            bv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            fidx_reg      <= '0;
            ac_reg        <= 1'b1;
            as_reg        <= 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        state_reg    <= S_SCAN;
                        cmd_reg      <= bffe_pkg::cmd_t'(command);
                        idx_reg      <= idx_in;
                        cnt_reg      <= cnt_in;
                        err_reg      <= err_in;
                        rd_ptr_reg   <= '0;
                        iss_done_reg <= 1'b0;
                        proc_vld_reg <= 1'b0;
                        lo_reg       <= '0;
                        bv_reg       <= 1'b0;
                        found_reg    <= 1'b0;
                        fidx_reg     <= '0;
                        ac_reg       <= 1'b1;
                        as_reg       <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (!iss_done_reg)
                    begin
                        proc_vld_reg  <= 1'b1;
                        proc_ptr_reg  <= rd_ptr_reg;
                        proc_last_reg <= (rd_ptr_reg == LAST_WORD);
                        if (rd_ptr_reg == LAST_WORD)
                        begin
                            iss_done_reg <= 1'b1;
                        end
                        else
                        begin
                            rd_ptr_reg <= rd_ptr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        proc_vld_reg <= 1'b0;
                    end

                    if (proc_vld_reg)
                    begin
                        lo_reg <= lo_reg + STEP;
                        bv_reg <= bv_reg | bv_w;
                        if ((new_word & used_m) != '0)
                        begin
                            ac_reg <= 1'b0;
                        end
                        if ((new_word & used_m) != used_m)
                        begin
                            as_reg <= 1'b0;
                        end
                        if (find_hit && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            fidx_reg  <= fidx_w[bffe_pkg::IDX_W-1:0];
                        end
                        // issue is already done here, so proc_vld_reg drops above
                        if (proc_last_reg)
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_FIN:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid         = (state_reg == S_FIN);
    assign res.bit_value     = bv_reg;
    assign res.found         = found_reg;
    assign res.found_index   = fidx_reg;
    assign res.index_error   = err_reg;
    assign res.all_clear     = ac_reg;
    assign res.all_set       = as_reg;

endmodule

// ----- hw/rtl/bitmap_find_first_engine_unit.sv -----
// channel   signals                               transfer when
// input     in_valid/in_ready, command, bit_index in_valid & in_ready
// output    out_valid/out_ready, result fields    out_valid & out_ready
// config    APB psel/penable/pwrite/paddr/pwdata  psel & penable & pwrite
//
// One pass over the word memory per command, one word read and one written back per
// cycle during the scan: in_ready drops at the input transfer and returns once the
// result moves to the output register, so the word scan paces the input transfers.
// Reset clears the bitmap through per-word valid bits, bit_count resets to 4096.
// A stalled output holds its result; the next item is taken meanwhile and
// its pass waits at the end until the output register frees up.
module bitmap_find_first_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bffe_pkg::CMD_W-1:0]    command,
    input  logic [bffe_pkg::IDX_W-1:0]    bit_index,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          bit_value,
    output logic                          found,
    output logic [bffe_pkg::IDX_W-1:0]    found_index,
    output logic                          index_error,
    output logic                          all_clear,
    output logic                          all_set,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bffe_pkg::PADDR_W-1:0]  paddr,
    input  logic [bffe_pkg::PDATA_W-1:0]  pwdata,
    output logic [bffe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic [bffe_pkg::CFG_W-1:0] bit_count_reg;
    logic                       out_valid_reg;
    bffe_pkg::res_t             res_reg;
    bffe_pkg::res_t             res;
    logic                       res_valid;
    logic                       res_take;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == bffe_pkg::REG_BIT_COUNT);
    assign prdata  = reg_sel ? bffe_pkg::PDATA_W'(bit_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= bffe_pkg::BIT_COUNT_RST;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            bit_count_reg <= pwdata[bffe_pkg::CFG_W-1:0];
        end
    end

    bffe_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .bit_index (bit_index),
        .bit_count (bit_count_reg),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
            res_reg       <= res;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bit_value   = res_reg.bit_value;
    assign found       = res_reg.found;
    assign found_index = res_reg.found_index;
    assign index_error = res_reg.index_error;
    assign all_clear   = res_reg.all_clear;
    assign all_set     = res_reg.all_set;

endmodule

// ----- hw/rtl/bffe_checker.sv -----
module bffe_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       bit_value,
    input logic                       found,
    input logic                       index_error,
    input logic                       all_clear,
    input logic                       all_set
);

    // one item at a time: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a found bit rules out one of the two uniform flags
    a_found_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> !index_error && !bit_value && !(all_clear && all_set))
        else $error("found result with inconsistent flags");

    a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> !found && !bit_value)
        else $error("index error result reports data");

endmodule

bind bitmap_find_first_engine_unit bffe_checker u_bffe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bit_value   (bit_value),
    .found       (found),
    .index_error (index_error),
    .all_clear   (all_clear),
    .all_set     (all_set)
);

// ----- tb/tb_top.sv -----
module tb_top;

    // command code 7 has no operation behind it
    localparam logic [bffe_pkg::CMD_W-1:0]   CMD_UNUSED     = 3'd7;
    localparam logic [bffe_pkg::PADDR_W-1:0] BIT_COUNT_ADDR = {bffe_pkg::REG_BIT_COUNT, 2'b00};
    localparam int                           DRAIN_CYCLES   = 200000;

    typedef struct {
        logic [bffe_pkg::CMD_W-1:0] op;
        logic [bffe_pkg::IDX_W-1:0] idx;
    } bitmap_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [bffe_pkg::CMD_W-1:0]   command = '0;
    logic [bffe_pkg::IDX_W-1:0]   bit_index = '0;

    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         bit_value;
    logic                         found;
    logic [bffe_pkg::IDX_W-1:0]   found_index;
    logic                         index_error;
    logic                         all_clear;
    logic                         all_set;

    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [bffe_pkg::PADDR_W-1:0] paddr = '0;
    logic [bffe_pkg::PDATA_W-1:0] pwdata = '0;
    logic [bffe_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    // shadow copy of the bitmap and of the count register
    logic [bffe_pkg::CAPACITY-1:0] bitmap_model = '0;
    int                            count_setting = int'(bffe_pkg::BIT_COUNT_RST);

    bitmap_req_t    cmd_backlog[$];
    bitmap_req_t    next_req;
    bffe_pkg::res_t predicted_replies[$];
    bffe_pkg::res_t want_reply;
    bffe_pkg::res_t got_reply;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int cmds_sent = 0;
    int replies_checked = 0;
    int find_hits = 0;
    int index_faults = 0;
    int settings_used = 0;

    bitmap_find_first_engine_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .bit_index   (bit_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bit_value   (bit_value),
        .found       (found),
        .found_index (found_index),
        .index_error (index_error),
        .all_clear   (all_clear),
        .all_set     (all_set),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // applies one command to the shadow bitmap and returns the reply it should give
    function automatic bffe_pkg::res_t apply_bitmap_cmd(
        input logic [bffe_pkg::CMD_W-1:0] op,
        input logic [bffe_pkg::IDX_W-1:0] idx);
        bffe_pkg::res_t r;
        int             used;
        logic           want;
        r = '0;
        used = (count_setting > bffe_pkg::CAPACITY) ? bffe_pkg::CAPACITY : count_setting;
        want = (op == bffe_pkg::CMD_FIND_SET);
        case (op)
            bffe_pkg::CMD_SET, bffe_pkg::CMD_CLEAR, bffe_pkg::CMD_TEST:
            begin
                if (int'(idx) >= used)
                begin
                    r.index_error = 1'b1;
                end
                else if (op == bffe_pkg::CMD_SET)
                begin
                    bitmap_model[idx] = 1'b1;
                end
                else if (op == bffe_pkg::CMD_CLEAR)
                begin
                    bitmap_model[idx] = 1'b0;
                end
                else
                begin
                    r.bit_value = bitmap_model[idx];
                end
            end
            bffe_pkg::CMD_FIND_SET, bffe_pkg::CMD_FIND_CLR:
            begin
                for (int i = 0; i < used; i++)
                begin
                    if (!r.found && bitmap_model[i] == want)
                    begin
                        r.found = 1'b1;
                        r.found_index = bffe_pkg::IDX_W'(i);
                    end
                end
            end
            bffe_pkg::CMD_SET_ALL:   bitmap_model = '1;
            bffe_pkg::CMD_CLEAR_ALL: bitmap_model = '0;
            default:                 ;
        endcase
        // padding above the used count never counts toward the flags
        r.all_clear = 1'b1;
        r.all_set = 1'b1;
        for (int i = 0; i < used; i++)
        begin
            if (bitmap_model[i])
            begin
                r.all_clear = 1'b0;
            end
            else
            begin
                r.all_set = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [bffe_pkg::IDX_W-1:0] pick_index(input int used, input int hot);
        int roll;
        roll = $urandom_range(0, 99);
        if (used == 0 || roll < 10)
        begin
            return bffe_pkg::IDX_W'($urandom);
        end
        if (roll < 20 && used < bffe_pkg::CAPACITY)
        begin
            return bffe_pkg::IDX_W'($urandom_range(used, bffe_pkg::CAPACITY - 1));
        end
        // a narrow hot window keeps finds landing somewhere other than bit 0
        if (roll < 55)
        begin
            return bffe_pkg::IDX_W'((hot + $urandom_range(0, 15)) % used);
        end
        return bffe_pkg::IDX_W'($urandom_range(0, used - 1));
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    task automatic push_cmd(input logic [bffe_pkg::CMD_W-1:0] op,
                            input logic [bffe_pkg::IDX_W-1:0] idx);
        cmd_backlog.push_back('{op, idx});
    endtask

    // returns once nothing is queued, in flight or awaited, or the bound runs out
    task automatic wait_idle();
        int n;
        n = 0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while ((cmd_backlog.size() != 0 || in_valid || predicted_replies.size() != 0)
               && n < DRAIN_CYCLES);
    endtask

    task automatic write_bit_count(input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BIT_COUNT_ADDR;
        pwdata <= bffe_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        count_setting = value & 32'h1FFF;
        settings_used++;
    endtask

    task automatic random_phase(input int count_value, input int n_items);
        int                         used;
        int                         hot;
        int                         roll;
        logic [bffe_pkg::CMD_W-1:0] op;
        wait_idle();
        write_bit_count(count_value);
        used = (count_setting > bffe_pkg::CAPACITY) ? bffe_pkg::CAPACITY : count_setting;
        hot = (used > 0) ? $urandom_range(0, used - 1) : 0;
        repeat (n_items)
        begin
            roll = $urandom_range(0, 99);
            op = (roll < 28) ? bffe_pkg::CMD_SET :
                 (roll < 46) ? bffe_pkg::CMD_CLEAR :
                 (roll < 60) ? bffe_pkg::CMD_TEST :
                 (roll < 74) ? bffe_pkg::CMD_FIND_SET :
                 (roll < 88) ? bffe_pkg::CMD_FIND_CLR :
                 (roll < 92) ? bffe_pkg::CMD_SET_ALL :
                 (roll < 96) ? bffe_pkg::CMD_CLEAR_ALL : CMD_UNUSED;
            push_cmd(op, pick_index(used, hot));
        end
    endtask

    // input side: valid holds with its payload until the transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= '0;
            bit_index <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_replies.push_back(apply_bitmap_cmd(command, bit_index));
                cmds_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req = cmd_backlog.pop_front();
                    in_valid <= 1'b1;
                    command <= next_req.op;
                    bit_index <= next_req.idx;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: random back-pressure, each transfer checked against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_reply = '{bit_value, found, found_index, index_error, all_clear, all_set};
                if (predicted_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: reply with nothing expected, expected none, actual %h",
                             $time, got_reply);
                end
                else
                begin
                    want_reply = predicted_replies.pop_front();
                    check_field("bit_value", int'(want_reply.bit_value),
                                int'(got_reply.bit_value));
                    check_field("found", int'(want_reply.found), int'(got_reply.found));
                    check_field("found_index", int'(want_reply.found_index),
                                int'(got_reply.found_index));
                    check_field("index_error", int'(want_reply.index_error),
                                int'(got_reply.index_error));
                    check_field("all_clear", int'(want_reply.all_clear),
                                int'(got_reply.all_clear));
                    check_field("all_set", int'(want_reply.all_set),
                                int'(got_reply.all_set));
                    replies_checked++;
                    if (got_reply.found)
                    begin
                        find_hits++;
                    end
                    if (got_reply.index_error)
                    begin
                        index_faults++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        send_idle_pct = 28;
        recv_idle_pct = 85;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // full-size map straight out of reset
        push_cmd(bffe_pkg::CMD_TEST, 12'd0);
        push_cmd(bffe_pkg::CMD_FIND_SET, 12'd0);
        push_cmd(bffe_pkg::CMD_FIND_CLR, 12'hFFF);
        push_cmd(bffe_pkg::CMD_SET, 12'd0);
        push_cmd(bffe_pkg::CMD_SET, 12'd4095);
        push_cmd(bffe_pkg::CMD_TEST, 12'd4095);
        push_cmd(bffe_pkg::CMD_CLEAR, 12'd0);
        push_cmd(bffe_pkg::CMD_FIND_SET, 12'd0);
        push_cmd(bffe_pkg::CMD_SET_ALL, 12'd0);
        push_cmd(bffe_pkg::CMD_FIND_CLR, 12'd0);
        push_cmd(bffe_pkg::CMD_CLEAR, 12'hAAA);
        push_cmd(bffe_pkg::CMD_FIND_CLR, 12'd0);
        push_cmd(bffe_pkg::CMD_TEST, 12'h555);
        push_cmd(CMD_UNUSED, 12'hFFF);
        push_cmd(bffe_pkg::CMD_CLEAR_ALL, 12'd0);

        // short map: out-of-range indices, the top in-range bit, a find and a set-all
        wait_idle();
        write_bit_count(100);
        push_cmd(bffe_pkg::CMD_SET, 12'd100);
        push_cmd(bffe_pkg::CMD_TEST, 12'd4095);
        push_cmd(bffe_pkg::CMD_SET, 12'd99);
        push_cmd(bffe_pkg::CMD_FIND_SET, 12'd0);
        push_cmd(bffe_pkg::CMD_SET_ALL, 12'd0);

        // empty map: every index is out of range, both flags read 1
        wait_idle();
        write_bit_count(0);
        push_cmd(bffe_pkg::CMD_SET, 12'd0);
        push_cmd(bffe_pkg::CMD_FIND_SET, 12'd0);
        push_cmd(bffe_pkg::CMD_FIND_CLR, 12'd0);
        push_cmd(CMD_UNUSED, 12'd0);

        // oversized count clamps to capacity; padding from set-all shows up again
        wait_idle();
        write_bit_count(8191);
        push_cmd(bffe_pkg::CMD_FIND_CLR, 12'd0);
        push_cmd(bffe_pkg::CMD_CLEAR, 12'd4095);
        push_cmd(bffe_pkg::CMD_FIND_CLR, 12'd0);

        random_phase(4096, 60);
        random_phase(1, 40);
        random_phase(65, 60);
        random_phase(8191, 60);

        wait_idle();
        send_idle_pct = 85;
        recv_idle_pct = 28;
        random_phase(0, 30);
        random_phase(64, 60);
        random_phase($urandom_range(1, 4096), 60);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(200, 60);
        random_phase(4095, 60);
        random_phase(4096, 60);

        wait_idle();
        repeat (bffe_pkg::NUM_WORDS + 8) @(posedge clk);
        if (predicted_replies.size() != 0 || cmd_backlog.size() != 0)
        begin
            mismatches++;
            $display("%0t: replies outstanding, expected 0, actual %0d",
                     $time, predicted_replies.size());
        end
        $display("summary: %0d commands sent, %0d replies checked over %0d count settings",
                 cmds_sent, replies_checked, settings_used);
        $display("summary: %0d finds located a bit, %0d index errors flagged",
                 find_hits, index_faults);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- bitmap_find_first_engine_unit.f -----
hw/rtl/bffe_pkg.sv
hw/rtl/bffe_core.sv
hw/rtl/bitmap_find_first_engine_unit.sv
hw/rtl/bffe_checker.sv
tb/tb_top.sv
